// File: rtl/core/signed_int_to_custom_radix_text_defines.svh
// Assertion macros shared by the radix text converter RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef SIGNED_INT_TO_CUSTOM_RADIX_TEXT_DEFINES_SVH
`define SIGNED_INT_TO_CUSTOM_RADIX_TEXT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SITRT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SITRT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sitrt_pkg.sv
// Shared types and constants of the radix text converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sitrt_pkg;

  localparam int AlphabetDepthDef = 256;
  localparam int NumberBitsDef    = 32;
  localparam int CharSpace        = 256;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;

  typedef enum logic [1:0] {
    ActClear   = 2'd0,
    ActAppend  = 2'd1,
    ActConvert = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         digit_char;
    logic signed [31:0] number;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       error;
  } out_item_t;

  // Alphabet update command decoded from the input channel
  typedef struct packed {
    logic       clear;
    logic       append;
    logic [7:0] ch;
  } alpha_cmd_t;

endpackage

// File: rtl/core/signed_int_to_custom_radix_text.sv
// Signed integer to text in a programmable radix.
// Input channel (in_valid_i / in_stall_o / in_item_i) carries one action per item:
// clear the alphabet, append one character, or convert a signed number. Output
// channel (out_valid_o / out_stall_i / out_item_o) carries characters: an
// optional '-', then the digits most significant first, last set on the final
// one. A bad or too short alphabet yields one item with error and last set.
// Clear and append produce nothing. An append is a seen-map read, then an
// update; a clear holds off input while the seen map is zeroed one entry a
// cycle. A conversion holds off input until its last character is in the
// output register; each digit comes from a bit-serial divider, and each
// character is then read back through the digit buffer read port.
// A stalled receiver holds the output register and the sequencer waits on it.
// Reset clears count and bad flag and runs the same clearing pass over the seen
// map before the first item is taken; the character memory needs no clearing.
// Depends on sitrt_pkg, the submodules sitrt_alpha, sitrt_div, sitrt_digbuf and
// the assertion header.
`timescale 1ns / 1ps
`include "signed_int_to_custom_radix_text_defines.svh"

module signed_int_to_custom_radix_text #(
  parameter int ALPHABET_DEPTH = sitrt_pkg::AlphabetDepthDef,
  parameter int NUMBER_BITS    = sitrt_pkg::NumberBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sitrt_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sitrt_pkg::out_item_t out_item_o
);
  import sitrt_pkg::*;

  localparam int AW = (ALPHABET_DEPTH > 1) ? $clog2(ALPHABET_DEPTH) : 1;
  localparam int IW = $clog2(NUMBER_BITS);
  localparam int NW = $clog2(NUMBER_BITS + 1);

  typedef enum logic [2:0] {
    StIdle,
    StErr,
    StSign,
    StDivGo,
    StDivWt,
    StRda,
    StEmRd,
    StEmWt
  } state_e;

  state_e                 state_q;
  logic [NUMBER_BITS-1:0] mag_q;
  logic [NW-1:0]          nd_q;
  logic [IW-1:0]          idx_q;
  logic                   out_valid_q;
  out_item_t              out_q;

  logic                   in_acc, out_free, out_load;
  logic [NUMBER_BITS-1:0] num_v, mag_d;
  logic                   neg;
  alpha_cmd_t             alpha_cmd;
  logic                   alpha_rd_en;
  logic [7:0]             alpha_rd_data, alpha_cnt;
  logic                   alpha_bad, alpha_busy;
  logic                   div_start, div_done;
  logic [NUMBER_BITS-1:0] div_quot;
  logic [7:0]             div_rem;
  logic                   db_wr_en, db_rd_en;
  logic [7:0]             db_rd_data;

  // Handshake and decode
  always_comb begin
    in_stall_o = (state_q != StIdle) || alpha_busy;
    in_acc     = in_valid_i && !in_stall_o;
    out_free   = !out_valid_q || !out_stall_i;
    out_load   = out_free &&
                 ((state_q == StErr) || (state_q == StSign) || (state_q == StEmWt));
    num_v      = NUMBER_BITS'(in_item_i.number);
    neg        = num_v[NUMBER_BITS-1];
    mag_d      = neg ? (~num_v + NUMBER_BITS'(1)) : num_v;

    alpha_cmd.clear  = in_acc && (in_item_i.action == ActClear);
    alpha_cmd.append = in_acc && (in_item_i.action == ActAppend);
    alpha_cmd.ch     = in_item_i.digit_char;

    div_start   = (state_q == StDivGo);
    alpha_rd_en = (state_q == StDivWt) && div_done;
    db_wr_en    = (state_q == StRda);
    db_rd_en    = (state_q == StEmRd);
  end

  sitrt_alpha #(
    .ALPHABET_DEPTH(ALPHABET_DEPTH)
  ) u_alpha (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (alpha_cmd),
    .rd_en_i  (alpha_rd_en),
    .rd_addr_i(div_rem[AW-1:0]),
    .rd_data_o(alpha_rd_data),
    .count_o  (alpha_cnt),
    .bad_o    (alpha_bad),
    .busy_o   (alpha_busy)
  );

  sitrt_div #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(mag_q),
    .divisor_i (alpha_cnt),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  sitrt_digbuf #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_digbuf (
    .clk_i    (clk_i),
    .wr_en_i  (db_wr_en),
    .wr_addr_i(nd_q[IW-1:0]),
    .wr_data_i(alpha_rd_data),
    .rd_en_i  (db_rd_en),
    .rd_addr_i(idx_q),
    .rd_data_o(db_rd_data)
  );

  // Conversion sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      nd_q        <= '0;
      idx_q       <= '0;
      mag_q       <= '0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc && (in_item_i.action == ActConvert)) begin
            mag_q <= mag_d;
            nd_q  <= '0;
            if (alpha_bad || (alpha_cnt < 8'd2)) begin
              state_q <= StErr;
            end else if (neg) begin
              state_q <= StSign;
            end else begin
              state_q <= StDivGo;
            end
          end
        end
        StErr: begin
          if (out_free) begin
            out_q   <= '{out_char: 8'd0, last: 1'b1, error: 1'b1};
            state_q <= StIdle;
          end
        end
        StSign: begin
          if (out_free) begin
            out_q   <= '{out_char: CharMinus, last: 1'b0, error: 1'b0};
            state_q <= StDivGo;
          end
        end
        StDivGo: begin
          state_q <= StDivWt;
        end
        StDivWt: begin
          if (div_done) begin
            mag_q   <= div_quot;
            state_q <= StRda;
          end
        end
        StRda: begin
          // digit written this cycle at nd_q
          nd_q <= nd_q + NW'(1);
          if (mag_q != '0) begin
            state_q <= StDivGo;
          end else begin
            idx_q   <= nd_q[IW-1:0];
            state_q <= StEmRd;
          end
        end
        StEmRd: begin
          state_q <= StEmWt;
        end
        StEmWt: begin
          if (out_free) begin
            out_q <= '{out_char: db_rd_data, last: (idx_q == '0), error: 1'b0};
            if (idx_q == '0) begin
              state_q <= StIdle;
            end else begin
              idx_q   <= idx_q - IW'(1);
              state_q <= StEmRd;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  `SITRT_ASSERT_IMP(a_err_last, clk_i, rst_ni, out_valid_q && out_q.error, out_q.last, "error not last")
  `SITRT_ASSERT_IMP(a_nd_range, clk_i, rst_ni, 1'b1, nd_q <= NW'(NUMBER_BITS), "digit count overflow")
  `SITRT_ASSERT_IMP(a_div_state, clk_i, rst_ni, div_done, state_q == StDivWt, "stray divider done")
  `SITRT_ASSERT_NXT(a_rd_then_wr, clk_i, rst_ni, alpha_rd_en, state_q == StRda, "alphabet read lost")

endmodule

// File: rtl/core/sitrt_alpha.sv
// Digit alphabet store: character memory, seen-byte memory, count and bad flag.
// Depends on sitrt_pkg.
`timescale 1ns / 1ps

module sitrt_alpha #(
  parameter int ALPHABET_DEPTH = sitrt_pkg::AlphabetDepthDef,
  localparam int AW = (ALPHABET_DEPTH > 1) ? $clog2(ALPHABET_DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sitrt_pkg::alpha_cmd_t cmd_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  output logic [7:0]            rd_data_o,
  output logic [7:0]            count_o,
  output logic                  bad_o,
  output logic                  busy_o
);
  import sitrt_pkg::*;

  // Count saturates at the smaller of depth and 255
  localparam logic [7:0] CntMax = 8'((ALPHABET_DEPTH < 255) ? ALPHABET_DEPTH : 255);
  // Last address of the seen-map clearing pass
  localparam logic [7:0] WipeLast = 8'(CharSpace - 1);

  typedef enum logic [1:0] {
    AlIdle,
    AlCheck,
    AlWipe
  } state_e;

  logic [7:0] mem_q [ALPHABET_DEPTH];
  logic [7:0] rd_data_q;
  logic       seen_q [CharSpace];
  logic       seen_rd_q;
  state_e     state_q;
  logic [7:0] ch_q;
  logic [7:0] wipe_q;
  logic [7:0] count_q;
  logic       bad_q;

  logic       is_sign, is_full, do_store, do_reject;
  logic       seen_rd_en, seen_we, seen_wd;
  logic [7:0] seen_wa;

  // Append classification, in the cycle after the seen-map read
  always_comb begin
    is_sign    = (ch_q == CharPlus) || (ch_q == CharMinus);
    is_full    = (count_q == CntMax);
    do_reject  = (state_q == AlCheck) && (is_sign || seen_rd_q || is_full);
    do_store   = (state_q == AlCheck) && !is_sign && !seen_rd_q && !is_full;
    seen_rd_en = (state_q == AlIdle) && cmd_i.append && (cmd_i.ch != 8'd0);
    seen_we    = do_store || (state_q == AlWipe);
    seen_wa    = (state_q == AlWipe) ? wipe_q : ch_q;
    seen_wd    = do_store;
  end

  // Control state: sequencing, count, bad flag, clearing pass address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AlWipe;
      ch_q    <= '0;
      wipe_q  <= '0;
      count_q <= '0;
      bad_q   <= 1'b0;
    end else begin
      unique case (state_q)
        AlIdle: begin
          if (cmd_i.clear) begin
            count_q <= '0;
            bad_q   <= 1'b0;
            wipe_q  <= '0;
            state_q <= AlWipe;
          end else if (seen_rd_en) begin
            ch_q    <= cmd_i.ch;
            state_q <= AlCheck;
          end
        end
        AlCheck: begin
          if (do_reject) begin
            bad_q <= 1'b1;
          end
          if (do_store) begin
            count_q <= count_q + 8'd1;
          end
          state_q <= AlIdle;
        end
        AlWipe: begin
          // one seen-map entry zeroed per cycle
          wipe_q <= wipe_q + 8'd1;
          if (wipe_q == WipeLast) begin
            state_q <= AlIdle;
          end
        end
        default: begin
          state_q <= AlIdle;
        end
      endcase
    end
  end

  // Character memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (do_store) begin
      mem_q[count_q[AW-1:0]] <= ch_q;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Seen-byte memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_q[seen_wa] <= seen_wd;
    end
    if (seen_rd_en) begin
      seen_rd_q <= seen_q[cmd_i.ch];
    end
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;
  assign bad_o     = bad_q;
  assign busy_o    = (state_q != AlIdle);

endmodule

// File: rtl/core/sitrt_div.sv
// Bit-serial restoring divider: magnitude by an 8-bit base, one bit a cycle.
// Depends on sitrt_pkg.
`timescale 1ns / 1ps

module sitrt_div #(
  parameter int NUMBER_BITS = sitrt_pkg::NumberBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NUMBER_BITS-1:0] dividend_i,
  input  logic [7:0]             divisor_i,
  output logic                   done_o,
  output logic [NUMBER_BITS-1:0] quot_o,
  output logic [7:0]             rem_o
);
  import sitrt_pkg::*;

  localparam int CW = $clog2(NUMBER_BITS + 1);

  logic [NUMBER_BITS-1:0] q_q, q_d;
  logic [7:0]             r_q, r_d;
  logic [CW-1:0]          cnt_q;
  logic                   busy_q, done_q;

  logic [8:0] r_try;
  logic [7:0] r_sub;
  logic       ge;

  // One restoring step
  always_comb begin
    r_try = {r_q, q_q[NUMBER_BITS-1]};
    ge    = (r_try >= {1'b0, divisor_i});
    r_sub = r_try[7:0] - divisor_i;
    r_d   = ge ? r_sub : r_try[7:0];
    q_d   = {q_q[NUMBER_BITS-2:0], ge};
  end

  // Step counter and handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(NUMBER_BITS);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
    end else if (busy_q) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

// File: rtl/core/sitrt_digbuf.sv
// Digit buffer memory: digits of one conversion, least significant first.
// Depends on sitrt_pkg.
`timescale 1ns / 1ps

module sitrt_digbuf #(
  parameter int NUMBER_BITS = sitrt_pkg::NumberBitsDef,
  localparam int IW = $clog2(NUMBER_BITS)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [IW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);
  import sitrt_pkg::*;

  logic [7:0] mem_q [NUMBER_BITS];
  logic [7:0] rd_data_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
